/* rtl/assert_macros.svh */
// Assertion macros used by the chain hash-reduce controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked every clock outside reset
`define RCHR_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define RCHR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RCHR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rchr_pkg.sv */
// Package: types, constants and SHA-256 helpers for the chain hash-reduce block
`timescale 1ns / 1ps
`default_nettype none
package rchr_pkg;

    localparam int POINT_W = 64;
    localparam int COL_W   = 16;
    localparam int TBL_W   = 8;
    localparam int CNT_W   = 16;
    localparam int DOM_W   = 63;
    localparam int OFS_W   = TBL_W + CNT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_NUMBER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SIZE  = 2'd2;

    localparam logic [TBL_W-1:0] TABLE_NUMBER_RST = 8'd0;
    localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 16'd1000;
    localparam logic [DOM_W-1:0] DOMAIN_SIZE_RST  = 63'd1000000;

    localparam logic [31:0] IV0 = 32'h6a09e667;
    localparam logic [31:0] IV1 = 32'hbb67ae85;
    localparam logic [31:0] IV2 = 32'h3c6ef372;
    localparam logic [31:0] IV3 = 32'ha54ff53a;
    localparam logic [31:0] IV4 = 32'h510e527f;
    localparam logic [31:0] IV5 = 32'h9b05688c;
    localparam logic [31:0] IV6 = 32'h1f83d9ab;
    localparam logic [31:0] IV7 = 32'h5be0cd19;

    // Padding words for an 8-byte message
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [31:0] LEN_WORD = 32'h00000040;

    typedef struct packed {
        logic load;
        logic sha_init;
        logic sha_round;
        logic sum;
        logic div_step;
        logic col_next;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic col_done;
        logic round_last;
        logic div_last;
    } status_t;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] v);
        bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        sha_k = k;
    endfunction

endpackage
`default_nettype wire

/* rtl/rainbow_chain_hash_reduce.sv */
// Top level: rainbow chain slice with SHA-256 hashing and column-dependent reduction
`timescale 1ns / 1ps
`default_nettype none
// Takes one word (start point, column range) at a time and returns one end point.
// Each column runs a set-up step, 64 SHA-256 rounds on a single round unit, one
// reduction add, 64 steps of a bit-serial restoring modulo and an update step.
// The result is registered once the output is free, and the controller then
// returns to idle to take the next word; an empty range passes the point
// straight through.
// The next word is taken while the previous result still waits on the output.
module rainbow_chain_hash_reduce (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rchr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rchr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [rchr_pkg::POINT_W-1:0]     start_point,
    input  wire logic [rchr_pkg::COL_W-1:0]       first_column,
    input  wire logic [rchr_pkg::COL_W-1:0]       stop_column,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [rchr_pkg::POINT_W-1:0]          end_point
);
    import rchr_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    rchr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rchr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_point  (start_point),
        .first_column (first_column),
        .stop_column  (stop_column),
        .cmd          (cmd),
        .status       (status),
        .end_point    (end_point)
    );

endmodule
`default_nettype wire

/* rtl/rchr_dp.sv */
// Datapath: config registers, SHA-256 round unit, reduction adder and serial modulo
`timescale 1ns / 1ps
`default_nettype none
module rchr_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [rchr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rchr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [rchr_pkg::POINT_W-1:0]   start_point,
    input  wire logic [rchr_pkg::COL_W-1:0]     first_column,
    input  wire logic [rchr_pkg::COL_W-1:0]     stop_column,
    input  wire rchr_pkg::cmd_t                 cmd,
    output rchr_pkg::status_t                   status,
    output logic [rchr_pkg::POINT_W-1:0]        end_point
);
    import rchr_pkg::*;

    logic [TBL_W-1:0]   table_number_reg;
    logic [CNT_W-1:0]   column_count_reg;
    logic [DOM_W-1:0]   domain_size_reg;

    logic [POINT_W-1:0] p_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   stop_reg;
    logic [POINT_W-1:0] end_point_reg;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] win_reg [16];
    logic [5:0]  round_reg;

    logic [POINT_W-1:0] x_reg;
    // x_reg is shifted empty by the divider, so the zero-modulus case keeps its own copy
    logic [POINT_W-1:0] xs_reg;
    logic [DOM_W-1:0]   rem_reg;
    logic [5:0]         div_cnt_reg;

    logic [31:0] t1, t2, w_next, sig0, sig1;
    logic [OFS_W-1:0]   offset;
    logic [POINT_W-1:0] digest, x_next;
    logic [POINT_W-1:0] trial, diff;
    logic [DOM_W-1:0]   rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_number_reg <= TABLE_NUMBER_RST;
            column_count_reg <= COLUMN_COUNT_RST;
            domain_size_reg  <= DOMAIN_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TABLE_NUMBER: table_number_reg <= cfg_data[TBL_W-1:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[CNT_W-1:0];
                CFG_DOMAIN_SIZE:  domain_size_reg  <= cfg_data[DOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        t1 = h_reg + (ror32(e_reg, 6) ^ ror32(e_reg, 11) ^ ror32(e_reg, 25))
           + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + sha_k(round_reg) + win_reg[0];
        t2 = (ror32(a_reg, 2) ^ ror32(a_reg, 13) ^ ror32(a_reg, 22))
           + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
        sig0 = ror32(win_reg[1], 7) ^ ror32(win_reg[1], 18) ^ (win_reg[1] >> 3);
        sig1 = ror32(win_reg[14], 17) ^ ror32(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_next = win_reg[0] + sig0 + win_reg[9] + sig1;
    end

    // Digest bytes 8..15 read as a little-endian word
    assign digest = {bswap32(IV3 + d_reg), bswap32(IV2 + c_reg)};
    assign offset = OFS_W'(table_number_reg) * OFS_W'(column_count_reg);
    assign x_next = digest + POINT_W'(col_reg) + POINT_W'(offset);

    assign trial    = {rem_reg, x_reg[POINT_W-1]};
    assign diff     = trial - POINT_W'(domain_size_reg);
    assign rem_next = (trial >= POINT_W'(domain_size_reg)) ? diff[DOM_W-1:0]
                                                           : trial[DOM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg    <= start_point;
            col_reg  <= first_column;
            stop_reg <= stop_column;
        end
        if (cmd.sha_init)
        begin
            a_reg <= IV0; b_reg <= IV1; c_reg <= IV2; d_reg <= IV3;
            e_reg <= IV4; f_reg <= IV5; g_reg <= IV6; h_reg <= IV7;
            win_reg[0] <= bswap32(p_reg[31:0]);
            win_reg[1] <= bswap32(p_reg[63:32]);
            win_reg[2] <= PAD_WORD;
            for (int i = 3; i < 15; i++)
            begin
                win_reg[i] <= '0;
            end
            win_reg[15] <= LEN_WORD;
        end
        else if (cmd.sha_round)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_next;
        end
        if (cmd.sum)
        begin
            x_reg   <= x_next;
            xs_reg  <= x_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            x_reg   <= {x_reg[POINT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.col_next)
        begin
            // zero modulus: the wrapped sum is kept as is
            p_reg   <= (domain_size_reg == '0) ? xs_reg : POINT_W'(rem_reg);
            col_reg <= col_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            end_point_reg <= p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.sha_init)
                round_reg <= '0;
            else if (cmd.sha_round)
                round_reg <= round_reg + 1'b1;
            if (cmd.sum)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign status.col_done   = (col_reg >= stop_reg);
    assign status.round_last = (round_reg == 6'd63);
    assign status.div_last   = (div_cnt_reg == 6'd63);
    assign end_point         = end_point_reg;

endmodule
`default_nettype wire

/* rtl/rchr_ctrl.sv */
// Controller: sequences load, 64 rounds, reduction sum, serial modulo and result hand-off
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rchr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire rchr_pkg::status_t  status,
    output rchr_pkg::cmd_t          cmd
);
    import rchr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_ROUND, S_SUM, S_DIV, S_NEXT, S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.sha_init  = (state_reg == S_CHECK) && !status.col_done;
        cmd.sha_round = (state_reg == S_ROUND);
        cmd.sum       = (state_reg == S_SUM);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.col_next  = (state_reg == S_NEXT);
        cmd.emit      = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_CHECK;
                S_CHECK:  state_reg <= status.col_done ? S_FINISH : S_ROUND;
                S_ROUND:  if (status.round_last) state_reg <= S_SUM;
                S_SUM:    state_reg <= S_DIV;
                S_DIV:    if (status.div_last) state_reg <= S_NEXT;
                S_NEXT:   state_reg <= S_CHECK;
                S_FINISH: if (out_free) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    `RCHR_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
    `RCHR_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid_reg || out_ready, "result overwritten")
    `RCHR_ASSERT_NXT(a_round_end, cmd.sha_round && status.round_last, state_reg == S_SUM,
                     "compression did not end after last round")
    `RCHR_ASSERT_NXT(a_accept, in_valid && in_ready, state_reg == S_CHECK,
                     "accepted word not started")

endmodule
`default_nettype wire
